// ===== rtl/tsi_pkg.sv =====
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types and constants for the threshold set intersection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsi_pkg;

    localparam int MAX_DEGREE_DEF = 1024;
    localparam int ID_W           = 31;
    localparam int THR_W          = 11;
    // count starts at this value; bounds start at list length plus this value
    localparam int BASE_COUNT     = 2;

    typedef enum logic [1:0] {
        MODE_APPEND_U = 2'd0,
        MODE_APPEND_V = 2'd1,
        MODE_START    = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic append;
        logic check_end;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic list_end;
        logic stop;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/tsi_ram.sv =====
// ----------------------------------------------------------------------------
// tsi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsi_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsi_ctrl
// Controller: sequences list loading, the merge walk and the result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsi_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    input  wire logic [1:0]   s_mode,
    output logic              s_ready,
    input  wire logic         m_ready,
    input  wire tsi_pkg::sts_t sts,
    output tsi_pkg::cmd_t     cmd
);

    tsi_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tsi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tsi_pkg::ST_IDLE: begin
                if (s_valid && tsi_pkg::mode_t'(s_mode) == tsi_pkg::MODE_START) begin
                    state_next = tsi_pkg::ST_FETCH;
                end
            end
            tsi_pkg::ST_FETCH: begin
                state_next = sts.list_end ? tsi_pkg::ST_DONE : tsi_pkg::ST_CMP;
            end
            tsi_pkg::ST_CMP: begin
                state_next = sts.stop ? tsi_pkg::ST_DONE : tsi_pkg::ST_FETCH;
            end
            tsi_pkg::ST_DONE: begin
                if (!sts.out_busy || m_ready) begin
                    state_next = tsi_pkg::ST_IDLE;
                end
            end
            default: state_next = tsi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            tsi_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (tsi_pkg::mode_t'(s_mode))
                        tsi_pkg::MODE_START: cmd.start = 1'b1;
                        tsi_pkg::MODE_APPEND_U,
                        tsi_pkg::MODE_APPEND_V: cmd.append = 1'b1;
                        default: ;
                    endcase
                end
            end
            tsi_pkg::ST_FETCH: cmd.check_end = 1'b1;
            tsi_pkg::ST_CMP:   cmd.step = 1'b1;
            tsi_pkg::ST_DONE:  cmd.load_out = !sts.out_busy || m_ready;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tsi_dp.sv =====
// ----------------------------------------------------------------------------
// tsi_dp
// Datapath: list stores, lengths, walk pointers, count and bounds, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsi_dp #(
    parameter int MAX_DEGREE = tsi_pkg::MAX_DEGREE_DEF,
    localparam int AW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1,
    localparam int LW = $clog2(MAX_DEGREE + 1)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [1:0]               s_mode,
    input  wire logic [tsi_pkg::ID_W-1:0] s_vertex_id,
    input  wire logic [tsi_pkg::THR_W-1:0] s_threshold,
    input  wire logic                     m_ready,
    output logic                          m_valid,
    output logic                          m_similar,
    output logic                          m_overflow,
    input  wire tsi_pkg::cmd_t            cmd,
    output tsi_pkg::sts_t                 sts
);

    // wide enough for length + 2 and for the threshold, compared unsigned
    localparam int CW = (LW + 2 > tsi_pkg::THR_W + 1) ? LW + 2 : tsi_pkg::THR_W + 1;

    logic [LW-1:0] u_len_reg, v_len_reg;
    logic [LW-1:0] i_reg, j_reg;
    logic [CW-1:0] cn_reg, du_reg, dv_reg;
    logic [CW-1:0] thr_reg;
    logic          drop_reg, res_reg;
    logic          m_valid_reg, m_similar_reg, m_overflow_reg;

    logic [tsi_pkg::ID_W-1:0] u_rdata, v_rdata;
    logic          u_full, v_full, is_u, is_v, we_u, we_v;
    logic          lt, gt, eq;
    logic [CW-1:0] du_m1, dv_m1, cn_p1;

    assign is_u   = tsi_pkg::mode_t'(s_mode) == tsi_pkg::MODE_APPEND_U;
    assign is_v   = tsi_pkg::mode_t'(s_mode) == tsi_pkg::MODE_APPEND_V;
    assign u_full = u_len_reg == LW'(MAX_DEGREE);
    assign v_full = v_len_reg == LW'(MAX_DEGREE);
    assign we_u   = cmd.append && is_u && !u_full;
    assign we_v   = cmd.append && is_v && !v_full;

    tsi_ram #(.WIDTH(tsi_pkg::ID_W), .DEPTH(MAX_DEGREE)) u_ram (
        .aclk  (aclk),
        .we    (we_u),
        .waddr (u_len_reg[AW-1:0]),
        .wdata (s_vertex_id),
        .raddr (i_reg[AW-1:0]),
        .rdata (u_rdata)
    );

    tsi_ram #(.WIDTH(tsi_pkg::ID_W), .DEPTH(MAX_DEGREE)) v_ram (
        .aclk  (aclk),
        .we    (we_v),
        .waddr (v_len_reg[AW-1:0]),
        .wdata (s_vertex_id),
        .raddr (j_reg[AW-1:0]),
        .rdata (v_rdata)
    );

    assign lt    = u_rdata < v_rdata;
    assign gt    = u_rdata > v_rdata;
    assign eq    = u_rdata == v_rdata;
    assign du_m1 = du_reg - CW'(1);
    assign dv_m1 = dv_reg - CW'(1);
    assign cn_p1 = cn_reg + CW'(1);

    assign sts.list_end = (i_reg >= u_len_reg) || (j_reg >= v_len_reg);
    assign sts.stop     = (lt && du_m1 < thr_reg) || (gt && dv_m1 < thr_reg)
                        || (eq && cn_p1 >= thr_reg);
    assign sts.out_busy = m_valid_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_len_reg   <= '0;
            v_len_reg   <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (we_u) begin
                u_len_reg <= u_len_reg + LW'(1);
            end
            if (we_v) begin
                v_len_reg <= v_len_reg + LW'(1);
            end
            if (cmd.append && ((is_u && u_full) || (is_v && v_full))) begin
                drop_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                u_len_reg   <= '0;
                v_len_reg   <= '0;
                drop_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // walk datapath
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            i_reg   <= '0;
            j_reg   <= '0;
            cn_reg  <= CW'(tsi_pkg::BASE_COUNT);
            du_reg  <= CW'(u_len_reg) + CW'(tsi_pkg::BASE_COUNT);
            dv_reg  <= CW'(v_len_reg) + CW'(tsi_pkg::BASE_COUNT);
            thr_reg <= CW'(s_threshold);
        end
        if (cmd.check_end) begin
            res_reg <= cn_reg >= thr_reg;
        end
        if (cmd.step) begin
            res_reg <= eq;
            if (lt) begin
                du_reg <= du_m1;
                i_reg  <= i_reg + LW'(1);
            end else if (gt) begin
                dv_reg <= dv_m1;
                j_reg  <= j_reg + LW'(1);
            end else begin
                cn_reg <= cn_p1;
                i_reg  <= i_reg + LW'(1);
                j_reg  <= j_reg + LW'(1);
            end
        end
        if (cmd.load_out) begin
            m_similar_reg  <= res_reg;
            m_overflow_reg <= drop_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_similar  = m_similar_reg;
    assign m_overflow = m_overflow_reg;

endmodule

`default_nettype wire

// ===== rtl/threshold_set_intersection.sv =====
// ----------------------------------------------------------------------------
// threshold_set_intersection
// Threshold test on the intersection of two sorted vertex id lists.
// ----------------------------------------------------------------------------
// Input requests (s_valid/s_ready): mode 0 appends s_vertex_id to list u,
// mode 1 to list v, mode 2 starts the comparison against s_threshold,
// mode 3 is ignored. Appends beyond MAX_DEGREE per list are dropped and
// reported through m_overflow of the next result.
// Appends and ignored requests are taken in the idle state and leave the
// block idle. A start request gives one result request (m_valid/m_ready)
// carrying m_similar and m_overflow. Each step of the merge walk reads
// both list RAMs in a fetch state, then compares in a compare state; the
// walk ends when a list runs out or a compare decides early, and the
// result is then loaded into the output register.
// The result sits in an output register: appends are taken while it waits,
// but the next start finishes only once the receiver has taken it.
// A start clears both lists and the overflow flag once its result is loaded.
// Reset (aresetn low, synchronous) empties both lists, clears the overflow
// flag and any pending result; list contents need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module threshold_set_intersection #(
    parameter int MAX_DEGREE = tsi_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_mode,
    input  wire logic [tsi_pkg::ID_W-1:0]  s_vertex_id,
    input  wire logic [tsi_pkg::THR_W-1:0] s_threshold,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_similar,
    output logic                           m_overflow
);

    tsi_pkg::cmd_t cmd;
    tsi_pkg::sts_t sts;

    tsi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tsi_dp #(.MAX_DEGREE(MAX_DEGREE)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_mode      (s_mode),
        .s_vertex_id (s_vertex_id),
        .s_threshold (s_threshold),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_similar   (m_similar),
        .m_overflow  (m_overflow),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Request-level test of the threshold set intersection block.
// ----------------------------------------------------------------------------
// Directed tasks cover empty lists, field extremes, both bound exits, low
// and unreachable thresholds, the ignored mode, unsorted lists and lists at
// and past capacity. Random pairs of lists, mostly sorted with shared ids, follow.
// Every accepted request updates a local copy of the block's lists. Each
// start queues the verdict that this copy gives. Results are compared
// field by field as the receiver takes them. Both sides idle at random,
// apart from one stretch where they do not.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tsi_pkg::*;

    localparam int CAPACITY      = MAX_DEGREE_DEF;
    localparam int RANDOM_ITEMS  = 490;
    localparam int IDLE_PERCENT  = 37;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic similar;
        logic overflow;
    } verdict_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_mode = MODE_NONE;
    logic [ID_W-1:0]   s_vertex_id = '0;
    logic [THR_W-1:0]  s_threshold = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_similar;
    logic              m_overflow;

    // local copy of the block's lists
    logic [ID_W-1:0]   u_ids [CAPACITY];
    logic [ID_W-1:0]   v_ids [CAPACITY];
    int                u_len = 0;
    int                v_len = 0;
    logic              dropped = 1'b0;

    verdict_t          pending_verdicts [$];
    int                mismatches = 0;
    bit                steady = 1'b0;

    threshold_set_intersection dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_vertex_id (s_vertex_id),
        .s_threshold (s_threshold),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_similar   (m_similar),
        .m_overflow  (m_overflow)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // merge walk over the local lists
    function automatic logic predict_similar(input int thr);
        int cn;
        int du;
        int dv;
        int i;
        int j;
        cn = BASE_COUNT;
        du = u_len + BASE_COUNT;
        dv = v_len + BASE_COUNT;
        i = 0;
        j = 0;
        while (i < u_len && j < v_len) begin
            if (u_ids[i] < v_ids[j]) begin
                du--;
                if (du < thr) return 1'b0;
                i++;
            end else if (u_ids[i] > v_ids[j]) begin
                dv--;
                if (dv < thr) return 1'b0;
                j++;
            end else begin
                cn++;
                if (cn >= thr) return 1'b1;
                i++;
                j++;
            end
        end
        return (cn >= thr);
    endfunction

    task automatic apply_request(input mode_t mode, input logic [ID_W-1:0] id,
                                 input logic [THR_W-1:0] thr);
        verdict_t v;
        case (mode)
            MODE_APPEND_U: begin
                if (u_len < CAPACITY) begin
                    u_ids[u_len] = id;
                    u_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            MODE_APPEND_V: begin
                if (v_len < CAPACITY) begin
                    v_ids[v_len] = id;
                    v_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            MODE_START: begin
                v.similar  = predict_similar(int'(thr));
                v.overflow = dropped;
                pending_verdicts.push_back(v);
                u_len = 0;
                v_len = 0;
                dropped = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    // Called and returns at a rising edge; valid stays high on return.
    task automatic send_request(input mode_t mode, input logic [31:0] id,
                                input logic [31:0] thr);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_vertex_id <= id[ID_W-1:0];
        s_threshold <= thr[THR_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_request(mode, id[ID_W-1:0], thr[THR_W-1:0]);
    endtask

    task automatic wait_for_verdicts();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin : check_verdicts
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with no start pending");
            end else begin
                want = pending_verdicts.pop_front();
                if (m_similar !== want.similar)
                    report_mismatch($sformatf("similar %b, want %b", m_similar, want.similar));
                if (m_overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, want %b", m_overflow,
                                              want.overflow));
            end
        end
    end

    task automatic test_empty_lists();
        send_request(MODE_START, 0, 0);
        send_request(MODE_START, 0, 2);
        send_request(MODE_START, 0, 3);
        send_request(MODE_APPEND_U, 5, 0);
        send_request(MODE_START, 0, 2047);
    endtask

    task automatic test_field_extremes();
        send_request(MODE_APPEND_U, 0, 0);
        send_request(MODE_APPEND_V, 0, 2047);
        // ignored request with every field bit set, mid-list
        send_request(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_APPEND_U, 32'h7FFF_FFFF, 0);
        send_request(MODE_APPEND_V, 32'h7FFF_FFFF, 0);
        send_request(MODE_START, 32'h7FFF_FFFF, 4);
    endtask

    task automatic test_bound_exits();
        send_request(MODE_APPEND_U, 1, 0);
        send_request(MODE_APPEND_U, 2, 0);
        send_request(MODE_APPEND_U, 3, 0);
        send_request(MODE_APPEND_V, 4, 0);
        send_request(MODE_START, 0, 5);
        send_request(MODE_APPEND_V, 1, 0);
        send_request(MODE_APPEND_V, 2, 0);
        send_request(MODE_APPEND_U, 9, 0);
        send_request(MODE_START, 0, 4);
    endtask

    task automatic test_low_threshold();
        send_request(MODE_APPEND_U, 1, 0);
        send_request(MODE_APPEND_U, 3, 0);
        send_request(MODE_APPEND_V, 3, 0);
        send_request(MODE_START, 0, 1);
    endtask

    task automatic test_unsorted();
        send_request(MODE_APPEND_U, 9, 0);
        send_request(MODE_APPEND_U, 3, 0);
        send_request(MODE_APPEND_U, 7, 0);
        send_request(MODE_APPEND_V, 3, 0);
        send_request(MODE_APPEND_V, 9, 0);
        send_request(MODE_START, 0, 3);
    endtask

    // u one past full; v matches the first and the last stored entry of u,
    // so the walk runs the u bound right down to the threshold
    task automatic test_list_capacity();
        for (int k = 0; k <= CAPACITY; k++) send_request(MODE_APPEND_U, 2 * k, 0);
        send_request(MODE_APPEND_V, 0, 0);
        send_request(MODE_APPEND_V, 2 * CAPACITY - 2, 0);
        send_request(MODE_START, 0, 4);
    endtask

    // one pair of lists and its start; returns the number of appends plus one for the start
    task automatic send_random_pair(output int count);
        logic [31:0] uq [$];
        logic [31:0] vq [$];
        logic [31:0] val;
        logic [31:0] step_max;
        int          n_steps;
        int          side;
        int          short_len;
        logic [31:0] thr;
        uq.delete();
        vq.delete();
        if ($urandom_range(99) < 8) begin
            // unsorted lists over a narrow range, so ids collide
            n_steps = $urandom_range(0, 12);
            for (int k = 0; k < n_steps; k++) uq.push_back($urandom_range(0, 15));
            n_steps = $urandom_range(0, 12);
            for (int k = 0; k < n_steps; k++) vq.push_back($urandom_range(0, 15));
        end else begin
            n_steps  = ($urandom_range(99) < 5) ? $urandom_range(25, 120)
                                                 : $urandom_range(0, 24);
            step_max = $urandom_range(1) ? 32'd3 : 32'h000F_FFFF;
            val = $urandom_range(0, 32'h7FFF_FFFF - n_steps * step_max);
            for (int k = 0; k < n_steps; k++) begin
                val  = val + $urandom_range(0, step_max);
                side = $urandom_range(0, 9);
                if (side < 4 || side >= 7) vq.push_back(val);
                if (side < 7) uq.push_back(val);
            end
        end
        count = uq.size() + vq.size() + 1;
        short_len = (uq.size() < vq.size()) ? uq.size() : vq.size();
        thr = ($urandom_range(99) < 10) ? $urandom_range(0, 2047)
                                        : $urandom_range(0, short_len + 4);
        while (uq.size() != 0 || vq.size() != 0) begin
            if ($urandom_range(99) < 4)
                send_request(MODE_NONE, $urandom, $urandom);
            if (vq.size() == 0 || (uq.size() != 0 && $urandom_range(1)))
                send_request(MODE_APPEND_U, uq.pop_front(), $urandom);
            else
                send_request(MODE_APPEND_V, vq.pop_front(), $urandom);
        end
        send_request(MODE_START, $urandom, thr);
    endtask

    task automatic test_random_pairs();
        int sent;
        int pairs;
        int count;
        sent  = 0;
        pairs = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = (sent > RANDOM_ITEMS / 3) && (sent < RANDOM_ITEMS / 2);
            send_random_pair(count);
            sent += count;
            pairs++;
            if (pairs % 20 == 0) wait_for_verdicts();
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_lists();
        test_field_extremes();
        test_bound_exits();
        test_low_threshold();
        test_unsorted();
        wait_for_verdicts();
        test_list_capacity();
        test_random_pairs();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tsi_pkg.sv
rtl/tsi_ram.sv
rtl/tsi_ctrl.sv
rtl/tsi_dp.sv
rtl/threshold_set_intersection.sv
tb/sv/tb_top.sv
